>>> rtl/core/irmsd_pkg.sv
// Package for the image RMS difference block: fixed widths, register
// indexes, sequencer state types and the engine handshake structs.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package irmsd_pkg;

  localparam int SAMPLE_W      = 16;  // width of a sample field on the port
  localparam int REG_BITS      = 13;  // width of a dimension register
  localparam int SUM_BITS      = 58;  // squared-difference accumulator
  localparam int FRAC_BITS     = 16;  // scale of the quotient before the root
  localparam int NUM_BITS      = SUM_BITS + FRAC_BITS;
  localparam int QUO_BITS      = 48;  // quotients at or above 2^48 saturate
  localparam int RMS_BITS      = 24;
  localparam int ROOT_STEPS    = RMS_BITS;
  localparam int NUM_CNT_BITS  = $clog2(NUM_BITS + 1);
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 4;

  localparam logic [REG_BITS-1:0] REG_RESET = REG_BITS'(1);
  localparam logic [RMS_BITS-1:0] RMS_ONE   = RMS_BITS'(256);
  localparam logic [RMS_BITS-1:0] RMS_MAX   = {RMS_BITS{1'b1}};

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_MISMATCH = 1'b1;

  typedef enum logic [1:0] {
    REG_WIDTH_FIRST,
    REG_WIDTH_SECOND,
    REG_HEIGHT_FIRST,
    REG_HEIGHT_SECOND
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_AREA,
    ST_SCALE,
    ST_START,
    ST_ROOT,
    ST_EMIT
  } ctl_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_DIVIDE,
    DV_ROOT,
    DV_DONE
  } eng_state_t;

  typedef struct packed {
    logic                start;
    logic [SUM_BITS-1:0] dividend;
  } eng_cmd_t;

  typedef struct packed {
    logic                done;
    logic [RMS_BITS-1:0] root;
  } eng_result_t;

endpackage

>>> rtl/core/irmsd_if.sv
// Stream interfaces of the image RMS difference block: pixel pairs in,
// results out, each with valid, ready and payload.
// Depends on irmsd_pkg for the field widths.
`timescale 1ns / 1ps

interface irmsd_in_if import irmsd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] red_a;
  logic [SAMPLE_W-1:0] green_a;
  logic [SAMPLE_W-1:0] blue_a;
  logic [SAMPLE_W-1:0] red_b;
  logic [SAMPLE_W-1:0] green_b;
  logic [SAMPLE_W-1:0] blue_b;
  logic                final_pixel;

  modport source (
    output valid, red_a, green_a, blue_a, red_b, green_b, blue_b, final_pixel,
    input  ready
  );
  modport sink (
    input  valid, red_a, green_a, blue_a, red_b, green_b, blue_b, final_pixel,
    output ready
  );
endinterface

interface irmsd_out_if import irmsd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RMS_BITS-1:0] rms_q8;
  logic                status;

  modport source (output valid, rms_q8, status, input ready);
  modport sink   (input valid, rms_q8, status, output ready);
endinterface

>>> rtl/core/irmsd_divsqrt.sv
// Divide-then-root engine: floor(sum * 2^16 / d) one quotient bit per cycle,
// then an integer square root two bits per cycle, on one shared subtractor.
// Depends on irmsd_pkg.
`timescale 1ns / 1ps

module irmsd_divsqrt import irmsd_pkg::*; #(
  parameter int DIV_BITS = 28
) (
  input  logic                clk,
  input  logic                rst_n,
  input  eng_cmd_t            cmd,
  input  logic [DIV_BITS-1:0] divisor,
  output eng_result_t         result
);

  localparam int SW = ((DIV_BITS + 1) > (QUO_BITS + 1)) ? DIV_BITS + 1 : QUO_BITS + 1;

  eng_state_t              state_r, state_nxt;
  logic [NUM_CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [NUM_BITS-1:0]     num_r, num_nxt;
  logic [DIV_BITS-1:0]     rem_r, rem_nxt;
  logic [DIV_BITS-1:0]     div_r, div_nxt;
  logic [QUO_BITS-1:0]     res_r, res_nxt;
  logic [QUO_BITS-1:0]     bit_r, bit_nxt;
  logic [RMS_BITS-1:0]     root_r, root_nxt;

  logic [DIV_BITS:0]       shifted;
  logic [QUO_BITS:0]       res_plus_bit;
  logic [SW-1:0]           op_a, op_b;
  logic [SW:0]             trial;
  logic                    borrow;
  logic                    div_last, root_last, saturate;

  // The one subtractor: remainder minus divisor, or radicand minus trial root.
  assign shifted      = {rem_r, num_r[NUM_BITS-1]};
  assign res_plus_bit = {1'b0, res_r} + {1'b0, bit_r};
  assign op_a   = (state_r == DV_DIVIDE) ? SW'(shifted) : SW'(num_r[QUO_BITS-1:0]);
  assign op_b   = (state_r == DV_DIVIDE) ? SW'(div_r) : SW'(res_plus_bit);
  assign trial  = {1'b0, op_a} - {1'b0, op_b};
  assign borrow = trial[SW];

  assign div_last  = (cnt_r == NUM_CNT_BITS'(NUM_BITS - 1));
  assign root_last = (cnt_r == NUM_CNT_BITS'(ROOT_STEPS - 1));
  assign saturate  = |num_nxt[NUM_BITS-1:QUO_BITS];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DV_IDLE: begin
        if (cmd.start) begin
          state_nxt = DV_DIVIDE;
        end
      end
      DV_DIVIDE: begin
        if (div_last) begin
          state_nxt = saturate ? DV_DONE : DV_ROOT;
        end
      end
      DV_ROOT: begin
        if (root_last) begin
          state_nxt = DV_DONE;
        end
      end
      DV_DONE: state_nxt = DV_IDLE;
      default: state_nxt = DV_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    root_nxt = root_r;
    unique case (state_r)
      DV_IDLE: begin
        if (cmd.start) begin
          num_nxt = {cmd.dividend, {FRAC_BITS{1'b0}}};
          rem_nxt = '0;
          div_nxt = divisor;
          cnt_nxt = '0;
        end
      end
      DV_DIVIDE: begin
        if (borrow) begin
          rem_nxt = shifted[DIV_BITS-1:0];
        end else begin
          rem_nxt = trial[DIV_BITS-1:0];
        end
        num_nxt = {num_r[NUM_BITS-2:0], ~borrow};
        cnt_nxt = div_last ? '0 : cnt_r + 1'b1;
        res_nxt = '0;
        bit_nxt = QUO_BITS'(1) << (QUO_BITS - 2);
        if (div_last && saturate) begin
          root_nxt = RMS_MAX;
        end
      end
      DV_ROOT: begin
        if (borrow) begin
          res_nxt = res_r >> 1;
        end else begin
          num_nxt[QUO_BITS-1:0] = trial[QUO_BITS-1:0];
          res_nxt = (res_r >> 1) + bit_r;
        end
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r + 1'b1;
        if (root_last) begin
          root_nxt = res_nxt[RMS_BITS-1:0];
        end
      end
      DV_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    res_r  <= res_nxt;
    bit_r  <= bit_nxt;
    root_r <= root_nxt;
  end

  assign result.done = (state_r == DV_DONE);
  assign result.root = root_r;

endmodule

>>> rtl/core/image_rms_difference.sv
// Top level of the image RMS difference block: configuration registers,
// squaring sequencer with one shared multiplier, and the result register.
// Depends on irmsd_pkg, irmsd_if and irmsd_divsqrt.
`timescale 1ns / 1ps

//  Channel   Direction  Handshake             Payload
//  in_ch     sink       valid / ready         red/green/blue of a and b, final_pixel
//  out_ch    source     valid / ready         rms_q8 (Q16.8), status
//  cfg_*     slave      APB, pready always 1  four 13-bit dimension registers
//
// A pixel pair that is not the last is handled in the acceptance cycle and
// four passes through the shared multiplier, one per color plus a final add.
// The last pair of an image then runs the divide engine (74 quotient bits,
// one per cycle) and the root (24 steps, skipped if the quotient saturates);
// a dimension mismatch or an empty overlap skips the engine.
// Reset is synchronous and active low; it clears the accumulator and sets
// every dimension register to 1. A stalled result sits in the output
// register while the next image's pixel pairs are already being accepted.

module image_rms_difference import irmsd_pkg::*; #(
  parameter int MAX_DIMENSION = 4096,
  parameter int SAMPLE_BITS   = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  irmsd_in_if.sink                 in_ch,
  irmsd_out_if.source              out_ch,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);

  // Clamped dimensions never exceed MAX_DIMENSION nor the register range.
  localparam int DIM_BITS  = $clog2(MAX_DIMENSION + 1);
  localparam int CW        = (DIM_BITS < REG_BITS) ? DIM_BITS : REG_BITS;
  localparam int CLAMP_VAL = (MAX_DIMENSION < (2 ** REG_BITS - 1)) ?
                             MAX_DIMENSION : (2 ** REG_BITS - 1);
  localparam int DW        = 2 * CW + 2;   // holds 3 * w * h
  localparam int MW        = (SAMPLE_BITS > CW) ? SAMPLE_BITS : CW;
  localparam logic [1:0] SQ_LAST = 2'd3;

  // ---------------------------------------------------------------------
  // Configuration registers. Only the register index bits are decoded.
  // ---------------------------------------------------------------------
  logic [REG_BITS-1:0] width_first_r, width_second_r;
  logic [REG_BITS-1:0] height_first_r, height_second_r;
  logic                cfg_write;
  cfg_reg_t            cfg_sel;
  logic [REG_BITS-1:0] cfg_read;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_sel    = cfg_reg_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_first_r   <= REG_RESET;
      width_second_r  <= REG_RESET;
      height_first_r  <= REG_RESET;
      height_second_r <= REG_RESET;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_WIDTH_FIRST:   width_first_r   <= cfg_pwdata[REG_BITS-1:0];
        REG_WIDTH_SECOND:  width_second_r  <= cfg_pwdata[REG_BITS-1:0];
        REG_HEIGHT_FIRST:  height_first_r  <= cfg_pwdata[REG_BITS-1:0];
        REG_HEIGHT_SECOND: height_second_r <= cfg_pwdata[REG_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_WIDTH_FIRST:   cfg_read = width_first_r;
      REG_WIDTH_SECOND:  cfg_read = width_second_r;
      REG_HEIGHT_FIRST:  cfg_read = height_first_r;
      REG_HEIGHT_SECOND: cfg_read = height_second_r;
      default:           cfg_read = '0;
    endcase
  end
  assign cfg_prdata = {{(CFG_DATA_BITS - REG_BITS){1'b0}}, cfg_read};

  // ---------------------------------------------------------------------
  // Overlap size and the special cases, from the raw register values.
  // ---------------------------------------------------------------------
  logic [REG_BITS-1:0] w_raw, h_raw, w_lim, h_lim, w_dist, h_dist;
  logic [CW-1:0]       w_clamp, h_clamp;
  logic                mismatch, empty_area;

  assign w_dist = (width_first_r > width_second_r) ? width_first_r - width_second_r
                                                   : width_second_r - width_first_r;
  assign h_dist = (height_first_r > height_second_r) ? height_first_r - height_second_r
                                                     : height_second_r - height_first_r;
  assign mismatch = (w_dist > REG_BITS'(1)) || (h_dist > REG_BITS'(1));

  assign w_raw = (width_first_r < width_second_r) ? width_first_r : width_second_r;
  assign h_raw = (height_first_r < height_second_r) ? height_first_r : height_second_r;
  assign w_lim = (w_raw > REG_BITS'(CLAMP_VAL)) ? REG_BITS'(CLAMP_VAL) : w_raw;
  assign h_lim = (h_raw > REG_BITS'(CLAMP_VAL)) ? REG_BITS'(CLAMP_VAL) : h_raw;
  assign w_clamp    = w_lim[CW-1:0];
  assign h_clamp    = h_lim[CW-1:0];
  assign empty_area = (w_raw == '0) || (h_raw == '0);

  // ---------------------------------------------------------------------
  // Sequencer and datapath registers.
  // ---------------------------------------------------------------------
  ctl_state_t           state_r, state_nxt;
  logic [1:0]           sq_cnt_r, sq_cnt_nxt;
  logic [SUM_BITS-1:0]  acc_r, acc_nxt;
  logic [2*MW-1:0]      prod_r, prod_nxt;
  logic [DW-1:0]        d_r, d_nxt;
  logic [RMS_BITS-1:0]  res_r, res_nxt;
  logic                 stat_r, stat_nxt;
  logic                 final_r;
  logic [SAMPLE_BITS-1:0] red_a_r, green_a_r, blue_a_r;
  logic [SAMPLE_BITS-1:0] red_b_r, green_b_r, blue_b_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [RMS_BITS-1:0]  out_rms_r, out_rms_nxt;
  logic                 out_status_r, out_status_nxt;

  logic                 in_accept;
  logic [SAMPLE_BITS-1:0] sel_a, sel_b, abs_diff;
  logic [MW-1:0]        mul_a, mul_b;
  logic [2*MW-1:0]      mul_p;
  logic [2*CW-1:0]      area;
  eng_cmd_t             eng_cmd;
  eng_result_t          eng_res;
  logic                 out_free;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Pick the color pair for this pass and take its absolute difference.
  always_comb begin
    unique case (sq_cnt_r)
      2'd0:    begin sel_a = red_a_r;   sel_b = red_b_r;   end
      2'd1:    begin sel_a = green_a_r; sel_b = green_b_r; end
      2'd2:    begin sel_a = blue_a_r;  sel_b = blue_b_r;  end
      default: begin sel_a = red_a_r;   sel_b = red_b_r;   end
    endcase
  end
  assign abs_diff = (sel_a > sel_b) ? sel_a - sel_b : sel_b - sel_a;

  // The shared multiplier squares differences and later forms w * h.
  assign mul_a = (state_r == ST_AREA) ? MW'(w_clamp) : MW'(abs_diff);
  assign mul_b = (state_r == ST_AREA) ? MW'(h_clamp) : MW'(abs_diff);
  assign mul_p = mul_a * mul_b;
  assign area  = prod_r[2*CW-1:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        if (sq_cnt_r == SQ_LAST) begin
          state_nxt = final_r ? ST_AREA : ST_IDLE;
        end
      end
      ST_AREA:  state_nxt = (mismatch || empty_area) ? ST_EMIT : ST_SCALE;
      ST_SCALE: state_nxt = ST_START;
      ST_START: state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (eng_res.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    sq_cnt_nxt       = sq_cnt_r;
    acc_nxt          = acc_r;
    prod_nxt         = prod_r;
    d_nxt            = d_r;
    res_nxt          = res_r;
    stat_nxt         = stat_r;
    eng_cmd.start    = 1'b0;
    eng_cmd.dividend = acc_r;
    out_valid_nxt    = out_valid_r && !out_ch.ready;
    out_rms_nxt      = out_rms_r;
    out_status_nxt   = out_status_r;
    unique case (state_r)
      ST_IDLE: begin
        sq_cnt_nxt = '0;
      end
      ST_SQUARE: begin
        // The product of one pass is added during the next one.
        prod_nxt   = mul_p;
        sq_cnt_nxt = sq_cnt_r + 1'b1;
        if (sq_cnt_r != 2'd0) begin
          acc_nxt = acc_r + SUM_BITS'(prod_r);
        end
      end
      ST_AREA: begin
        prod_nxt = mul_p;
        if (mismatch) begin
          res_nxt  = RMS_ONE;
          stat_nxt = STATUS_MISMATCH;
          acc_nxt  = '0;
        end else if (empty_area) begin
          res_nxt  = '0;
          stat_nxt = STATUS_OK;
          acc_nxt  = '0;
        end
      end
      ST_SCALE: begin
        d_nxt = {2'b00, area} + {1'b0, area, 1'b0};
      end
      ST_START: begin
        // The engine takes the sum now, so the next image may start fresh.
        eng_cmd.start = 1'b1;
        acc_nxt       = '0;
      end
      ST_ROOT: begin
        if (eng_res.done) begin
          res_nxt  = eng_res.root;
          stat_nxt = STATUS_OK;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_rms_nxt    = res_r;
          out_status_nxt = stat_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sq_cnt_r    <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sq_cnt_r    <= sq_cnt_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r       <= prod_nxt;
    d_r          <= d_nxt;
    res_r        <= res_nxt;
    stat_r       <= stat_nxt;
    out_rms_r    <= out_rms_nxt;
    out_status_r <= out_status_nxt;
    if (in_accept) begin
      red_a_r   <= in_ch.red_a[SAMPLE_BITS-1:0];
      green_a_r <= in_ch.green_a[SAMPLE_BITS-1:0];
      blue_a_r  <= in_ch.blue_a[SAMPLE_BITS-1:0];
      red_b_r   <= in_ch.red_b[SAMPLE_BITS-1:0];
      green_b_r <= in_ch.green_b[SAMPLE_BITS-1:0];
      blue_b_r  <= in_ch.blue_b[SAMPLE_BITS-1:0];
      final_r   <= in_ch.final_pixel;
    end
  end

  // Quotient and square root of the finished sum.
  irmsd_divsqrt #(
    .DIV_BITS (DW)
  ) u_divsqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (eng_cmd),
    .divisor (d_r),
    .result  (eng_res)
  );

  assign out_ch.valid  = out_valid_r;
  assign out_ch.rms_q8 = out_rms_r;
  assign out_ch.status = out_status_r;

endmodule

>>> rtl/core/irmsd_checker.sv
// Port-level assertions for the image RMS difference block and the bind
// that attaches them to the top level. Depends on irmsd_pkg.
`timescale 1ns / 1ps

module irmsd_checker import irmsd_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [RMS_BITS-1:0] out_rms_q8,
  input logic                out_status
);

  // A held result keeps its payload until it is taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_rms_q8) && $stable(out_status))
  else $error("result changed while stalled");

  // Every accepted pixel pair leaves the block not ready in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
  else $error("input accepted on back-to-back cycles");

  // A new result only appears after the sequencer has been working.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
  else $error("result appeared while the block was idle");

  // Reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
  else $error("result pending after reset");

endmodule

bind image_rms_difference irmsd_checker u_irmsd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_rms_q8 (out_ch.rms_q8),
  .out_status (out_ch.status)
);
